[design/rrq_pkg.sv]
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants for the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CHOSEN_W    = 8;
  localparam int unsigned LEN_W       = 5;

  typedef enum logic [1:0] {
    CMD_ADMIT  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  // broadcast control to every cell
  typedef struct packed {
    logic               do_admit;
    logic               do_remove;
    logic               do_rotate;
    logic [ID_BITS-1:0] id;
  } rrq_ctl_t;

  // per-cell position relative to the queue length
  typedef struct packed {
    logic occ;
    logic tail;
    logic append;
  } rrq_pos_t;

endpackage

[design/rrq_cell.sv]
// ----------------------------------------------------------------------------
// rrq_cell
// One queue slot: compares against the broadcast id, passes the found flag on,
// loads an admitted id, or its neighbour's id on a close-up or rotate.
// ----------------------------------------------------------------------------
module rrq_cell (
  input  logic                        clk,
  input  rrq_pkg::rrq_ctl_t           ctl,
  input  rrq_pkg::rrq_pos_t           pos,
  input  logic                        found_in,
  input  logic [rrq_pkg::ID_BITS-1:0] next_slot,
  input  logic [rrq_pkg::ID_BITS-1:0] head_slot,
  output logic                        found_out,
  output logic [rrq_pkg::ID_BITS-1:0] slot
);

  logic [rrq_pkg::ID_BITS-1:0] slot_r;
  logic [rrq_pkg::ID_BITS-1:0] slot_nxt;
  logic                        match;

  assign match     = pos.occ && (slot_r == ctl.id);
  assign found_out = found_in || match;
  assign slot      = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    priority if (ctl.do_admit && pos.append) begin
      slot_nxt = ctl.id;
    end else if (ctl.do_remove && pos.occ && !pos.tail && found_out) begin
      slot_nxt = next_slot;
    end else if (ctl.do_rotate && pos.tail) begin
      slot_nxt = head_slot;
    end else if (ctl.do_rotate && pos.occ) begin
      slot_nxt = next_slot;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

[design/round_robin_ready_queue_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_ready_queue_unit
// Ordered ready queue of thread ids held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_cmd, in_thread_id) is taken when start is high and busy is
//   low. in_cmd: admit appends the id at the tail, remove deletes it wherever
//   it stands, next returns the head id and moves it to the tail.
//   The result appears on out_chosen_thread, out_status and out_queue_length
//   for exactly one cycle with out_valid high, in the cycle after busy. busy is
//   high in the cycle after acceptance, while the cell chain compares, passes
//   the found flag along and shifts; no new item is taken while busy. The found
//   flag ripples through all cells in the busy cycle.
//   The receiver cannot stall: out_valid is a strobe and must be captured.
//   Reset (rst_n low, synchronous) empties the queue and drops any item in
//   flight; slot contents are not cleared, as only slots below the length
//   are ever read.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [rrq_pkg::ID_BITS-1:0]   in_thread_id,
  output logic                          out_valid,
  output logic [rrq_pkg::CHOSEN_W-1:0]  out_chosen_thread,
  output logic [2:0]                    out_status,
  output logic [rrq_pkg::LEN_W-1:0]     out_queue_length
);

  localparam int unsigned D = rrq_pkg::QUEUE_DEPTH;

  logic                          busy_r;
  rrq_pkg::cmd_t                 cmd_r;
  logic [rrq_pkg::ID_BITS-1:0]   id_r;
  logic [rrq_pkg::CNT_W-1:0]     count_r;
  logic [rrq_pkg::CNT_W-1:0]     count_nxt;
  logic                          out_valid_r;
  logic [rrq_pkg::CHOSEN_W-1:0]  chosen_r;
  logic [rrq_pkg::CHOSEN_W-1:0]  chosen_nxt;
  rrq_pkg::status_t              status_r;
  rrq_pkg::status_t              status_nxt;

  rrq_pkg::rrq_ctl_t             ctl;
  rrq_pkg::rrq_pos_t             pos   [D];
  logic [D:0]                    found;
  logic [rrq_pkg::ID_BITS-1:0]   slots [D+1];
  logic                          empty;
  logic                          full;

  assign busy  = busy_r;
  assign empty = (count_r == '0);
  assign full  = (count_r == rrq_pkg::CNT_W'(D));

  assign found[0] = 1'b0;
  assign slots[D] = '0;

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      assign pos[g].occ    = (count_r > rrq_pkg::CNT_W'(g));
      assign pos[g].tail   = (count_r == rrq_pkg::CNT_W'(g + 1));
      assign pos[g].append = (count_r == rrq_pkg::CNT_W'(g));

      rrq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .pos       (pos[g]),
        .found_in  (found[g]),
        .next_slot (slots[g+1]),
        .head_slot (slots[0]),
        .found_out (found[g+1]),
        .slot      (slots[g])
      );
    end
  endgenerate

  always_comb begin
    ctl.id        = id_r;
    ctl.do_admit  = busy_r && (cmd_r == rrq_pkg::CMD_ADMIT) && !full && !found[D];
    ctl.do_remove = busy_r && (cmd_r == rrq_pkg::CMD_REMOVE) && found[D];
    ctl.do_rotate = busy_r && (cmd_r == rrq_pkg::CMD_NEXT) && !empty;
  end

  always_comb begin
    count_nxt  = count_r;
    chosen_nxt = '0;
    status_nxt = rrq_pkg::ST_OK;
    unique case (cmd_r)
      rrq_pkg::CMD_ADMIT: begin
        priority if (full) begin
          status_nxt = rrq_pkg::ST_FULL;
        end else if (found[D]) begin
          status_nxt = rrq_pkg::ST_DUP;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      rrq_pkg::CMD_REMOVE: begin
        priority if (empty) begin
          status_nxt = rrq_pkg::ST_EMPTY;
        end else if (!found[D]) begin
          status_nxt = rrq_pkg::ST_NOTFOUND;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      rrq_pkg::CMD_NEXT: begin
        if (empty) begin
          status_nxt = rrq_pkg::ST_EMPTY;
        end else begin
          chosen_nxt = rrq_pkg::CHOSEN_W'(slots[0]);
        end
      end
      default: begin
        status_nxt = rrq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= start && !busy_r;
      out_valid_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cmd_r <= rrq_pkg::cmd_t'(in_cmd);
      id_r  <= in_thread_id;
    end
    if (busy_r) begin
      chosen_r <= chosen_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_thread = chosen_r;
  assign out_status        = status_r;
  assign out_queue_length  = rrq_pkg::LEN_W'(count_r);

  a_busy_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("busy held longer than one cycle");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_valid_r)
    else $error("no result after processing cycle");

  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rrq_pkg::CNT_W'(D))
    else $error("queue length beyond depth");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> count_r == $past(count_r))
    else $error("queue length changed while idle");

  a_chosen_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != rrq_pkg::ST_OK) |-> chosen_r == '0)
    else $error("thread chosen on a failed item");

endmodule

[tb/rrq_checker.sv]
// ----------------------------------------------------------------------------
// rrq_checker
// Watches both channels of the ready queue, keeps its own copy of the queue
// and compares every result strobe with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrq_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic [rrq_pkg::ID_BITS-1:0]  in_thread_id,
  input  logic                         out_valid,
  input  logic [rrq_pkg::CHOSEN_W-1:0] out_chosen_thread,
  input  logic [2:0]                   out_status,
  input  logic [rrq_pkg::LEN_W-1:0]    out_queue_length,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [rrq_pkg::CHOSEN_W-1:0] chosen;
    rrq_pkg::status_t             status;
    logic [rrq_pkg::LEN_W-1:0]    length;
  } sched_outcome_t;

  logic [rrq_pkg::ID_BITS-1:0] ready_ids[$];
  sched_outcome_t              outcomes_due[$];
  int                          mismatch_total = 0;

  function automatic sched_outcome_t apply_queue_op(rrq_pkg::cmd_t op,
                                                    logic [rrq_pkg::ID_BITS-1:0] tid);
    sched_outcome_t              res;
    int                          pos;
    logic [rrq_pkg::ID_BITS-1:0] head;
    res.chosen = '0;
    res.status = rrq_pkg::ST_OK;
    pos = -1;
    foreach (ready_ids[i]) begin
      if (pos < 0 && ready_ids[i] == tid) pos = i;
    end
    case (op)
      rrq_pkg::CMD_ADMIT: begin
        if (ready_ids.size() >= rrq_pkg::QUEUE_DEPTH) res.status = rrq_pkg::ST_FULL;
        else if (pos >= 0) res.status = rrq_pkg::ST_DUP;
        else ready_ids.push_back(tid);
      end
      rrq_pkg::CMD_REMOVE: begin
        if (ready_ids.size() == 0) res.status = rrq_pkg::ST_EMPTY;
        else if (pos < 0) res.status = rrq_pkg::ST_NOTFOUND;
        else ready_ids.delete(pos);
      end
      rrq_pkg::CMD_NEXT: begin
        if (ready_ids.size() == 0) begin
          res.status = rrq_pkg::ST_EMPTY;
        end else begin
          head = ready_ids.pop_front();
          ready_ids.push_back(head);
          res.chosen = rrq_pkg::CHOSEN_W'(head);
        end
      end
      default: ;
    endcase
    res.length = rrq_pkg::LEN_W'(ready_ids.size());
    return res;
  endfunction

  always @(posedge clk) begin
    sched_outcome_t want;
    if (!rst_n) begin
      ready_ids.delete();
      outcomes_due.delete();
    end else begin
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: unexpected result chosen=%0d status=%0d length=%0d",
                     $realtime, out_chosen_thread, out_status, out_queue_length);
          mismatch_total++;
        end else begin
          want = outcomes_due.pop_front();
          if (out_chosen_thread !== want.chosen || out_status !== want.status ||
              out_queue_length !== want.length) begin
            if (mismatch_total < 10)
              $display("%0t: mismatch exp/got chosen %0d/%0d status %0d/%0d length %0d/%0d",
                       $realtime, want.chosen, out_chosen_thread, want.status, out_status,
                       want.length, out_queue_length);
            mismatch_total++;
          end
        end
      end
      if (start && !busy)
        outcomes_due.push_back(apply_queue_op(rrq_pkg::cmd_t'(in_cmd), in_thread_id));
    end
    fail_count <= mismatch_total;
    pending    <= outcomes_due.size();
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the round-robin ready queue: a directed pass over
// empty, single, full, duplicate and absent-id cases, then random phases that
// alternately fill and drain the queue with random gaps between items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic [1:0]                   in_cmd = '0;
  logic [rrq_pkg::ID_BITS-1:0]  in_thread_id = '0;
  logic                         busy;
  logic                         out_valid;
  logic [rrq_pkg::CHOSEN_W-1:0] out_chosen_thread;
  logic [2:0]                   out_status;
  logic [rrq_pkg::LEN_W-1:0]    out_queue_length;
  int                           fail_count;
  int                           pending;
  bit                           no_idle = 1'b0;

  always #10 clk = ~clk;

  round_robin_ready_queue_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_chosen_thread (out_chosen_thread),
    .out_status        (out_status),
    .out_queue_length  (out_queue_length)
  );

  rrq_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_chosen_thread (out_chosen_thread),
    .out_status        (out_status),
    .out_queue_length  (out_queue_length),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  task automatic send_item(rrq_pkg::cmd_t op, logic [rrq_pkg::ID_BITS-1:0] tid);
    int roll;
    int gap;
    start        <= 1'b1;
    in_cmd       <= op;
    in_thread_id <= tid;
    do @(posedge clk); while (busy);
    roll = $urandom_range(0, 9);
    if (no_idle || roll < 6) gap = 0;
    else if (roll < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int waited;
    int r;
    int admit_w;
    int remove_w;
    int base;
    bit fill_phase;
    logic [rrq_pkg::ID_BITS-1:0] tid;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(rrq_pkg::CMD_NEXT, 8'd0);
    send_item(rrq_pkg::CMD_REMOVE, 8'd9);
    send_item(rrq_pkg::CMD_NONE, 8'hff);
    send_item(rrq_pkg::CMD_ADMIT, 8'd255);
    send_item(rrq_pkg::CMD_NEXT, 8'd0);
    send_item(rrq_pkg::CMD_NEXT, 8'hff);
    send_item(rrq_pkg::CMD_ADMIT, 8'd0);
    send_item(rrq_pkg::CMD_ADMIT, 8'd0);
    send_item(rrq_pkg::CMD_REMOVE, 8'd7);
    send_item(rrq_pkg::CMD_REMOVE, 8'd255);
    for (int k = 1; k <= 15; k++) send_item(rrq_pkg::CMD_ADMIT, rrq_pkg::ID_BITS'(k * 17));
    send_item(rrq_pkg::CMD_ADMIT, 8'd0);
    send_item(rrq_pkg::CMD_ADMIT, 8'd200);
    send_item(rrq_pkg::CMD_NEXT, 8'd0);
    send_item(rrq_pkg::CMD_REMOVE, 8'd136);
    send_item(rrq_pkg::CMD_REMOVE, 8'd0);
    send_item(rrq_pkg::CMD_NONE, 8'h00);

    // random phases
    fill_phase = 1'b0;
    base = 0;
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) begin
        base       = $urandom_range(0, 232);
        fill_phase = ~fill_phase;
        no_idle    = ($urandom_range(0, 3) == 0);
      end
      admit_w  = fill_phase ? 55 : 20;
      remove_w = fill_phase ? 15 : 45;
      if ($urandom_range(0, 4) == 0) tid = rrq_pkg::ID_BITS'($urandom_range(0, 255));
      else tid = rrq_pkg::ID_BITS'(base + $urandom_range(0, 22));
      r = $urandom_range(0, 99);
      if (r < 5) send_item(rrq_pkg::CMD_NONE, tid);
      else if (r < 5 + admit_w) send_item(rrq_pkg::CMD_ADMIT, tid);
      else if (r < 5 + admit_w + remove_w) send_item(rrq_pkg::CMD_REMOVE, tid);
      else send_item(rrq_pkg::CMD_NEXT, tid);
    end
    start <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 1000);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
